// File: hw/rtl/dwr_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Shared widths, request and status codes, and the control codes of the
// storage chain and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dwr_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int WORD_W           = 64;
    localparam int REQ_W            = 3;
    localparam int COUNT_OUT_W      = 5;
    localparam int STATUS_W         = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_REVERSE    = 3'd4,
        REQ_PEEK       = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_INSERT = 2'd1,
        CH_REMOVE = 2'd2,
        CH_WRITE  = 2'd3
    } t_chain_op;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LOWER = 2'd1,
        CELL_FROM_UPPER = 2'd2,
        CELL_LOAD       = 2'd3
    } t_cell_op;

endpackage

`default_nettype wire

// File: hw/rtl/dwr_cell.sv
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one word and, each cycle, keeps it, takes a neighbor's word or loads
// a new word.
// ----------------------------------------------------------------------------
`default_nettype none

module dwr_cell (
    input  wire logic                      i_clk,
    input  wire dwr_pkg::t_cell_op         i_op,
    input  wire logic [dwr_pkg::WORD_W-1:0] i_lower,
    input  wire logic [dwr_pkg::WORD_W-1:0] i_upper,
    input  wire logic [dwr_pkg::WORD_W-1:0] i_value,
    output logic      [dwr_pkg::WORD_W-1:0] o_word
);
    import dwr_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        case (i_op)
            CELL_HOLD:       n_word = r_word;
            CELL_FROM_LOWER: n_word = i_lower;
            CELL_FROM_UPPER: n_word = i_upper;
            CELL_LOAD:       n_word = i_value;
            default:         n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// File: hw/rtl/dwr_chain.sv
// ----------------------------------------------------------------------------
// Deque storage chain
// A row of cells anchored at cell 0. Insert shifts every word one cell up and
// puts the new word in cell 0, remove shifts every word one cell down, and
// write loads the new word into the cell at the given position.
// ----------------------------------------------------------------------------
`default_nettype none

module dwr_chain #(
    parameter int CAPACITY = dwr_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                       i_clk,
    input  wire dwr_pkg::t_chain_op         i_op,
    input  wire logic [CNT_W-1:0]           i_pos,
    input  wire logic [dwr_pkg::WORD_W-1:0] i_value,
    output logic      [dwr_pkg::WORD_W-1:0] o_head
);
    import dwr_pkg::*;

    logic [WORD_W-1:0] cell_word [CAPACITY];

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_op          cell_op;
        logic [WORD_W-1:0] lower;
        logic [WORD_W-1:0] upper;

        if (gi == 0) begin : g_first
            assign lower = i_value;
        end else begin : g_inner
            assign lower = cell_word[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign upper = cell_word[gi];
        end else begin : g_below
            assign upper = cell_word[gi+1];
        end

        always_comb begin
            case (i_op)
                CH_HOLD:   cell_op = CELL_HOLD;
                CH_INSERT: cell_op = CELL_FROM_LOWER;
                CH_REMOVE: cell_op = CELL_FROM_UPPER;
                CH_WRITE:  cell_op = (i_pos == CNT_W'(gi)) ? CELL_LOAD : CELL_HOLD;
                default:   cell_op = CELL_HOLD;
            endcase
        end

        dwr_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_lower (lower),
            .i_upper (upper),
            .i_value (i_value),
            .o_word  (cell_word[gi])
        );
    end

    assign o_head = cell_word[0];

endmodule

`default_nettype wire

// File: hw/rtl/deque_with_reverse_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue with reverse
// Bounded deque of 64-bit words with push, pop, reverse and peek requests.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock cycle and returns one result beat
// for each, in the cycle after acceptance; a new request is taken while the
// previous result is still held, as long as the output side is not stalled.
// The words are kept twice, in two chains of cells: one chain has the
// physical first word in its cell 0 and the other has the physical last word
// in its cell 0, so both ends are always read from fixed cells. Reverse
// only toggles which chain supplies the front word.
`default_nettype none

module deque_with_reverse_top #(
    parameter int CAPACITY = dwr_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [dwr_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [dwr_pkg::WORD_W-1:0]      i_item_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [dwr_pkg::WORD_W-1:0]      o_front_word,
    output logic      [dwr_pkg::WORD_W-1:0]      o_back_word,
    output logic      [dwr_pkg::COUNT_OUT_W-1:0] o_entry_count,
    output logic                                 o_is_empty,
    output logic      [dwr_pkg::STATUS_W-1:0]    o_status
);
    import dwr_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic              r_out_valid;
    logic              n_out_valid;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_rev;
    logic              n_rev;
    t_status           r_status;
    t_status           n_status;

    logic              accept;
    logic              full;
    logic              empty;
    logic              at_first;
    t_chain_op         first_op;
    t_chain_op         last_op;
    t_chain_op         first_chain_op;
    t_chain_op         last_chain_op;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] last_word;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);

    always_comb begin
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = ST_DONE;
        at_first = 1'b0;
        first_op = CH_HOLD;
        last_op  = CH_HOLD;
        case (i_req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    at_first = (i_req_type == REQ_PUSH_FRONT) ^ r_rev;
                    first_op = at_first ? CH_INSERT : CH_WRITE;
                    last_op  = at_first ? CH_WRITE : CH_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    at_first = (i_req_type == REQ_POP_FRONT) ^ r_rev;
                    first_op = at_first ? CH_REMOVE : CH_HOLD;
                    last_op  = at_first ? CH_HOLD : CH_REMOVE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            REQ_REVERSE: begin
                n_rev = ~r_rev;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        first_chain_op = CH_HOLD;
        last_chain_op  = CH_HOLD;
        if (accept) begin
            first_chain_op = first_op;
            last_chain_op  = last_op;
        end
    end

    assign n_out_valid = accept | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_status    <= ST_DONE;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_count  <= n_count;
                r_rev    <= n_rev;
                r_status <= n_status;
            end
        end
    end

    dwr_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_first_chain (
        .i_clk   (i_clk),
        .i_op    (first_chain_op),
        .i_pos   (r_count),
        .i_value (i_item_value),
        .o_head  (first_word)
    );

    dwr_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_last_chain (
        .i_clk   (i_clk),
        .i_op    (last_chain_op),
        .i_pos   (r_count),
        .i_value (i_item_value),
        .o_head  (last_word)
    );

    assign count_ext     = {{COUNT_OUT_W{1'b0}}, r_count};
    assign o_out_valid   = r_out_valid;
    assign o_front_word  = empty ? '0 : (r_rev ? last_word : first_word);
    assign o_back_word   = empty ? '0 : (r_rev ? first_word : last_word);
    assign o_entry_count = count_ext[COUNT_OUT_W-1:0];
    assign o_is_empty    = empty;
    assign o_status      = r_status;

endmodule

`default_nettype wire
